// ===== hdl/hrmc_pkg.sv =====
// ---------------------------------------------------------------------------
// hrmc_pkg
// Shared codes, field widths and reset values of the two-hub route cost unit.
// ---------------------------------------------------------------------------
package hrmc_pkg;

   typedef enum logic [1:0] {
      CMD_WR_DIST    = 2'd0,
      CMD_WR_TRAFFIC = 2'd1,
      CMD_WR_HUB     = 2'd2,
      CMD_QUERY      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_WRITE_OK = 2'd0,
      STAT_ROUTE    = 2'd1,
      STAT_REJECT   = 2'd2
   } status_type;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HUBS_PER_NODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLLECT_RATE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSFER_RATE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTRIB_RATE = 3'd4;

   localparam int NC_W   = 7;
   localparam int HPN_W  = 3;
   localparam int RATE_W = 16;
   localparam int DIST_W = 16;
   localparam int TRAF_W = 16;
   localparam int IDX_W  = 6;
   localparam int VAL_W  = 16;
   localparam int TERM_W = 32;
   localparam int PART_W = 33;
   localparam int SUM_W  = 34;
   localparam int COST_W = 50;

   localparam int REQ_W = 32;
   localparam int RSP_W = 64;

   localparam logic [NC_W-1:0]   NODE_COUNT_RST = 7'd64;
   localparam logic [HPN_W-1:0]  HUBS_RST       = 3'd1;
   localparam logic [RATE_W-1:0] RATE_RST       = 16'd256;

   typedef struct packed {
      logic vld;
      logic first;
   } cand_ctl_type;

endpackage

// ===== hdl/hrmc_tables.sv =====
// ---------------------------------------------------------------------------
// hrmc_tables
// Distance, traffic and hub list memories. One write port each and
// registered reads.
// ---------------------------------------------------------------------------
module hrmc_tables
   import hrmc_pkg::*;
#(
   parameter int NODE_W = 6,
   parameter int SLOT_W = 2
) (
   input  logic                       clock,
   input  logic                       dist_we,
   input  logic [2*NODE_W-1:0]        dist_wa,
   input  logic [DIST_W-1:0]          dist_wd,
   input  logic                       dist_re,
   input  logic [2*NODE_W-1:0]        dist_ra_a,
   input  logic [2*NODE_W-1:0]        dist_ra_b,
   output logic [DIST_W-1:0]          dist_qa,
   output logic [DIST_W-1:0]          dist_qb,
   input  logic                       traf_we,
   input  logic [2*NODE_W-1:0]        traf_wa,
   input  logic [TRAF_W-1:0]          traf_wd,
   input  logic                       traf_re,
   input  logic [2*NODE_W-1:0]        traf_ra,
   output logic [TRAF_W-1:0]          traf_q,
   input  logic                       hub_we,
   input  logic [NODE_W+SLOT_W-1:0]   hub_wa,
   input  logic [NODE_W-1:0]          hub_wd,
   input  logic                       hub_re,
   input  logic [NODE_W+SLOT_W-1:0]   hub_ra_a,
   input  logic [NODE_W+SLOT_W-1:0]   hub_ra_b,
   output logic [NODE_W-1:0]          hub_qa,
   output logic [NODE_W-1:0]          hub_qb
);

   localparam int DIST_DEPTH = 1 << (2 * NODE_W);
   localparam int HUB_DEPTH  = 1 << (NODE_W + SLOT_W);

   logic [DIST_W-1:0] dist_mem [DIST_DEPTH];
   logic [TRAF_W-1:0] traf_mem [DIST_DEPTH];
   logic [NODE_W-1:0] hub_mem  [HUB_DEPTH];

   logic [DIST_W-1:0] dist_qa_ff;
   logic [DIST_W-1:0] dist_qb_ff;
   logic [TRAF_W-1:0] traf_q_ff;
   logic [NODE_W-1:0] hub_qa_ff;
   logic [NODE_W-1:0] hub_qb_ff;

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_wa] <= dist_wd;
      end
      if (dist_re) begin
         dist_qa_ff <= dist_mem[dist_ra_a];
         dist_qb_ff <= dist_mem[dist_ra_b];
      end
   end

   always_ff @(posedge clock) begin
      if (traf_we) begin
         traf_mem[traf_wa] <= traf_wd;
      end
      if (traf_re) begin
         traf_q_ff <= traf_mem[traf_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (hub_we) begin
         hub_mem[hub_wa] <= hub_wd;
      end
      if (hub_re) begin
         hub_qa_ff <= hub_mem[hub_ra_a];
         hub_qb_ff <= hub_mem[hub_ra_b];
      end
   end

   assign dist_qa = dist_qa_ff;
   assign dist_qb = dist_qb_ff;
   assign traf_q  = traf_q_ff;
   assign hub_qa  = hub_qa_ff;
   assign hub_qb  = hub_qb_ff;

endmodule

// ===== hdl/hrmc_eval.sv =====
// ---------------------------------------------------------------------------
// hrmc_eval
// Candidate cost pipeline: adds the per-hub end terms, the hub-to-hub term,
// scales by traffic and keeps the first least-cost hub pair.
// ---------------------------------------------------------------------------
module hrmc_eval
   import hrmc_pkg::*;
#(
   parameter int NODE_W = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  cand_ctl_type        cand_ctl,
   input  logic [NODE_W-1:0]   cand_a,
   input  logic [NODE_W-1:0]   cand_b,
   input  logic [TERM_W-1:0]   term_a,
   input  logic [TERM_W-1:0]   term_b,
   input  logic [DIST_W-1:0]   hub_dist,
   input  logic [RATE_W-1:0]   transfer_rate,
   input  logic [TRAF_W-1:0]   traffic,
   output logic                busy,
   output logic [COST_W-1:0]   best_cost,
   output logic [NODE_W-1:0]   best_a,
   output logic [NODE_W-1:0]   best_b
);

   cand_ctl_type      ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;
   logic [NODE_W-1:0] a1_ff, a2_ff, a3_ff, a4_ff;
   logic [NODE_W-1:0] b1_ff, b2_ff, b3_ff, b4_ff;
   logic [PART_W-1:0] part1_ff, part2_ff;
   logic [TERM_W-1:0] prod2_ff;
   logic [SUM_W-1:0]  sum3_ff;
   logic [COST_W-1:0] cost4_ff;
   logic [COST_W-1:0] cost4_in;
   logic [COST_W-1:0] best_cost_ff;
   logic [NODE_W-1:0] best_a_ff, best_b_ff;
   logic              take;

   assign cost4_in = COST_W'(traffic) * COST_W'(sum3_ff);
   assign take     = ctl4_ff.vld && (ctl4_ff.first || (cost4_ff < best_cost_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else begin
         ctl1_ff <= cand_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff    <= cand_a;
      b1_ff    <= cand_b;
      part1_ff <= PART_W'(term_a) + PART_W'(term_b);
      a2_ff    <= a1_ff;
      b2_ff    <= b1_ff;
      part2_ff <= part1_ff;
      prod2_ff <= TERM_W'(transfer_rate) * TERM_W'(hub_dist);
      a3_ff    <= a2_ff;
      b3_ff    <= b2_ff;
      sum3_ff  <= SUM_W'(part2_ff) + SUM_W'(prod2_ff);
      a4_ff    <= a3_ff;
      b4_ff    <= b3_ff;
      cost4_ff <= cost4_in;
      if (take) begin
         best_cost_ff <= cost4_ff;
         best_a_ff    <= a4_ff;
         best_b_ff    <= b4_ff;
      end
   end

   assign busy      = ctl1_ff.vld || ctl2_ff.vld || ctl3_ff.vld || ctl4_ff.vld;
   assign best_cost = best_cost_ff;
   assign best_a    = best_a_ff;
   assign best_b    = best_b_ff;

endmodule

// ===== hdl/two_hub_route_min_cost_unit.sv =====
// ---------------------------------------------------------------------------
// two_hub_route_min_cost_unit
// Loads distance, traffic and hub tables and answers least-cost two-hub
// route queries over every pair of assigned hubs.
// ---------------------------------------------------------------------------
// Writes and rejected requests: result registered on acceptance.
// Route query with r hubs per node: hub and end-term prep, then one hub pair
// per cycle through a distance memory read port, then the cost pipe.
// One request in flight; the next is taken while a result waits on rsp_.
// Reset restores control and config registers; table memories keep their
// contents and are not cleared.
module two_hub_route_min_cost_unit
   import hrmc_pkg::*;
#(
   parameter int MAX_NODES     = 64,
   parameter int MAX_HUB_SLOTS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // command[1:0], row_node[7:2], col_node[13:8], hub_slot[15:14],
   // write_value[31:16]
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[1:0], route_cost[51:2], first_hub[57:52], second_hub[63:58]
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int SLOT_W = (MAX_HUB_SLOTS > 1) ? $clog2(MAX_HUB_SLOTS) : 1;
   localparam int NCW    = ($clog2(MAX_NODES + 1) > NC_W) ? $clog2(MAX_NODES + 1) : NC_W;
   localparam int SCW    = ($clog2(MAX_HUB_SLOTS + 1) > HPN_W) ?
                           $clog2(MAX_HUB_SLOTS + 1) : HPN_W;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PREP   = 6'b000010,
      ST_PDRAIN = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_SDRAIN = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   // config
   logic [NC_W-1:0]   node_count_ff;
   logic [HPN_W-1:0]  hubs_ff;
   logic [RATE_W-1:0] collect_rate_ff;
   logic [RATE_W-1:0] transfer_rate_ff;
   logic [RATE_W-1:0] distrib_rate_ff;

   // request fields
   cmd_type           req_cmd;
   logic [IDX_W-1:0]  req_row;
   logic [IDX_W-1:0]  req_col;
   logic [1:0]        req_slot;
   logic [VAL_W-1:0]  req_value;
   logic [NODE_W-1:0] row_idx;
   logic [NODE_W-1:0] col_idx;

   logic [NCW-1:0] eff_n;
   logic [SCW-1:0] eff_r;
   logic           row_ok, col_ok, slot_ok, val_ok, r_ok;
   logic           acc, write_ok, query_go;
   logic           wr_dist, wr_traf, wr_hub;

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] row_ff, col_ff;
   logic [SLOT_W-1:0] k_ff, k_in;
   logic [SLOT_W-1:0] hi_ff, hi_in;
   logic [SLOT_W-1:0] hj_ff, hj_in;
   logic              k_last, hi_last, hj_last;

   logic              p1_vld_ff, p2_vld_ff;
   logic [SLOT_W-1:0] p1_slot_ff, p2_slot_ff;
   logic [NODE_W-1:0] hub_a_ff  [MAX_HUB_SLOTS];
   logic [NODE_W-1:0] hub_b_ff  [MAX_HUB_SLOTS];
   logic [TERM_W-1:0] term_a_ff [MAX_HUB_SLOTS];
   logic [TERM_W-1:0] term_b_ff [MAX_HUB_SLOTS];

   logic                 scan;
   logic [2*NODE_W-1:0]  dist_ra_a;
   logic [DIST_W-1:0]    dist_qa, dist_qb;
   logic [TRAF_W-1:0]    traf_q;
   logic [NODE_W-1:0]    hub_qa, hub_qb;

   cand_ctl_type         cand_ctl;
   logic                 eval_busy;
   logic [COST_W-1:0]    best_cost;
   logic [NODE_W-1:0]    best_a, best_b;

   status_type        res_status_ff;
   logic [COST_W-1:0] res_cost_ff;
   logic [IDX_W-1:0]  res_a_ff, res_b_ff;
   logic              out_free, out_load;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   // ---- config port ----
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff    <= NODE_COUNT_RST;
         hubs_ff          <= HUBS_RST;
         collect_rate_ff  <= RATE_RST;
         transfer_rate_ff <= RATE_RST;
         distrib_rate_ff  <= RATE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NODE_COUNT:    node_count_ff    <= csr_wdata[NC_W-1:0];
            CSR_HUBS_PER_NODE: hubs_ff          <= csr_wdata[HPN_W-1:0];
            CSR_COLLECT_RATE:  collect_rate_ff  <= csr_wdata[RATE_W-1:0];
            CSR_TRANSFER_RATE: transfer_rate_ff <= csr_wdata[RATE_W-1:0];
            CSR_DISTRIB_RATE:  distrib_rate_ff  <= csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- request decode ----
   assign req_cmd   = cmd_type'(req_tdata[1:0]);
   assign req_row   = req_tdata[7:2];
   assign req_col   = req_tdata[13:8];
   assign req_slot  = req_tdata[15:14];
   assign req_value = req_tdata[31:16];
   assign row_idx   = NODE_W'(req_row);
   assign col_idx   = NODE_W'(req_col);

   assign eff_n = (NCW'(node_count_ff) > NCW'(MAX_NODES)) ? NCW'(MAX_NODES)
                                                           : NCW'(node_count_ff);
   assign eff_r = (SCW'(hubs_ff) > SCW'(MAX_HUB_SLOTS)) ? SCW'(MAX_HUB_SLOTS)
                                                         : SCW'(hubs_ff);

   assign row_ok  = NCW'(req_row) < eff_n;
   assign col_ok  = NCW'(req_col) < eff_n;
   assign slot_ok = SCW'(req_slot) < eff_r;
   assign val_ok  = req_value < VAL_W'(eff_n);
   assign r_ok    = eff_r != '0;

   assign req_tready = state_ff == ST_IDLE;
   assign acc        = req_tvalid && req_tready;

   assign write_ok = ((req_cmd == CMD_WR_DIST || req_cmd == CMD_WR_TRAFFIC) && row_ok && col_ok)
                  || (req_cmd == CMD_WR_HUB && row_ok && slot_ok && val_ok);
   assign wr_dist  = acc && req_cmd == CMD_WR_DIST && row_ok && col_ok;
   assign wr_traf  = acc && req_cmd == CMD_WR_TRAFFIC && row_ok && col_ok;
   assign wr_hub   = acc && req_cmd == CMD_WR_HUB && row_ok && slot_ok && val_ok;
   assign query_go = acc && req_cmd == CMD_QUERY && row_ok && col_ok && r_ok;

   // ---- sequencer ----
   assign k_last  = SCW'(k_ff)  == (eff_r - SCW'(1));
   assign hi_last = SCW'(hi_ff) == (eff_r - SCW'(1));
   assign hj_last = SCW'(hj_ff) == (eff_r - SCW'(1));
   assign scan    = state_ff == ST_SCAN;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign out_load = (state_ff == ST_DONE) && out_free;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      hi_in    = hi_ff;
      hj_in    = hj_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (query_go) begin
                  state_in = ST_PREP;
                  k_in     = '0;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_PREP: begin
            k_in = k_ff + 1'b1;
            if (k_last) begin
               state_in = ST_PDRAIN;
            end
         end
         ST_PDRAIN: begin
            if (!p1_vld_ff && !p2_vld_ff) begin
               state_in = ST_SCAN;
               hi_in    = '0;
               hj_in    = '0;
            end
         end
         ST_SCAN: begin
            if (hj_last) begin
               hj_in = '0;
               hi_in = hi_ff + 1'b1;
               if (hi_last) begin
                  state_in = ST_SDRAIN;
               end
            end else begin
               hj_in = hj_ff + 1'b1;
            end
         end
         ST_SDRAIN: begin
            if (!eval_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         hi_ff        <= '0;
         hj_ff        <= '0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         k_ff      <= k_in;
         hi_ff     <= hi_in;
         hj_ff     <= hj_in;
         p1_vld_ff <= state_ff == ST_PREP;
         p2_vld_ff <= p1_vld_ff;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- per-slot hub and end-term prep, results ----
   always_ff @(posedge clock) begin
      if (acc) begin
         row_ff <= row_idx;
         col_ff <= col_idx;
      end
      p1_slot_ff <= k_ff;
      p2_slot_ff <= p1_slot_ff;
      if (p1_vld_ff) begin
         hub_a_ff[p1_slot_ff] <= hub_qa;
         hub_b_ff[p1_slot_ff] <= hub_qb;
      end
      if (p2_vld_ff) begin
         term_a_ff[p2_slot_ff] <= TERM_W'(collect_rate_ff) * TERM_W'(dist_qa);
         term_b_ff[p2_slot_ff] <= TERM_W'(distrib_rate_ff) * TERM_W'(dist_qb);
      end
      if (acc) begin
         res_status_ff <= write_ok ? STAT_WRITE_OK : STAT_REJECT;
         res_cost_ff   <= '0;
         res_a_ff      <= '0;
         res_b_ff      <= '0;
      end else if (state_ff == ST_SDRAIN && !eval_busy) begin
         res_status_ff <= STAT_ROUTE;
         res_cost_ff   <= best_cost;
         res_a_ff      <= IDX_W'(best_a);
         res_b_ff      <= IDX_W'(best_b);
      end
      if (out_load) begin
         rsp_data_ff <= {res_b_ff, res_a_ff, res_cost_ff, res_status_ff};
      end
   end

   // ---- tables ----
   assign dist_ra_a = scan ? {hub_a_ff[hi_ff], hub_b_ff[hj_ff]} : {row_ff, hub_qa};

   hrmc_tables #(
      .NODE_W (NODE_W),
      .SLOT_W (SLOT_W)
   ) u_tables (
      .clock     (clock),
      .dist_we   (wr_dist),
      .dist_wa   ({row_idx, col_idx}),
      .dist_wd   (req_value),
      .dist_re   (p1_vld_ff || scan),
      .dist_ra_a (dist_ra_a),
      .dist_ra_b ({hub_qb, col_ff}),
      .dist_qa   (dist_qa),
      .dist_qb   (dist_qb),
      .traf_we   (wr_traf),
      .traf_wa   ({row_idx, col_idx}),
      .traf_wd   (req_value),
      .traf_re   (acc),
      .traf_ra   ({row_idx, col_idx}),
      .traf_q    (traf_q),
      .hub_we    (wr_hub),
      .hub_wa    ({row_idx, SLOT_W'(req_slot)}),
      .hub_wd    (NODE_W'(req_value)),
      .hub_re    (state_ff == ST_PREP),
      .hub_ra_a  ({row_ff, k_ff}),
      .hub_ra_b  ({col_ff, k_ff}),
      .hub_qa    (hub_qa),
      .hub_qb    (hub_qb)
   );

   // ---- candidate evaluation ----
   assign cand_ctl.vld   = scan;
   assign cand_ctl.first = (hi_ff == '0) && (hj_ff == '0);

   hrmc_eval #(
      .NODE_W (NODE_W)
   ) u_eval (
      .clock         (clock),
      .reset         (reset),
      .cand_ctl      (cand_ctl),
      .cand_a        (hub_a_ff[hi_ff]),
      .cand_b        (hub_b_ff[hj_ff]),
      .term_a        (term_a_ff[hi_ff]),
      .term_b        (term_b_ff[hj_ff]),
      .hub_dist      (dist_qa),
      .transfer_rate (transfer_rate_ff),
      .traffic       (traf_q),
      .busy          (eval_busy),
      .best_cost     (best_cost),
      .best_a        (best_a),
      .best_b        (best_b)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- assertions ----
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_prep_drained: assert property (@(posedge clock) disable iff (reset)
      scan |-> (!p1_vld_ff && !p2_vld_ff))
      else $error("prep pipe still busy during scan");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside done state");

   a_route_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && res_status_ff == STAT_ROUTE) |-> !eval_busy)
      else $error("route result taken while candidates in flight");

endmodule

// ===== tb/two_hub_route_min_cost_unit_test.sv =====
// ---------------------------------------------------------------------------
// two_hub_route_min_cost_unit_test
// Loads the distance, traffic and hub tables through the request stream and
// fires route queries that only touch loaded entries. Every response is
// checked against an in-bench cost calculator or a fixed directed answer.
// Config is swept across phases; both sides stall at random except phase 1.
// ---------------------------------------------------------------------------
module two_hub_route_min_cost_unit_test;
   import hrmc_pkg::*;

   localparam int NODES = 64;
   localparam int SLOTS = 4;

   typedef struct packed {
      logic [15:0] value;
      logic [1:0]  slot;
      logic [5:0]  col;
      logic [5:0]  row;
      cmd_type     cmd;
   } route_req_type;

   typedef struct packed {
      logic [5:0]  hub_b;
      logic [5:0]  hub_a;
      logic [49:0] cost;
      status_type  status;
   } route_rsp_type;

   typedef struct {
      route_req_type rq;
      bit            typed;
      route_rsp_type ans;
   } lane_item_type;

   typedef struct {
      bit              is_csr;
      logic [2:0]      idx;
      logic [15:0]     wdata;
      lane_item_type   item;
   } plan_step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // table mirror and written flags
   logic [15:0] dist_mem [NODES*NODES];
   logic [15:0] traf_mem [NODES*NODES];
   logic [5:0]  hub_mem  [NODES*SLOTS];
   bit          dist_ok  [NODES*NODES];
   bit          traf_ok  [NODES*NODES];
   bit          hub_ok   [NODES*SLOTS];

   logic [6:0]  cfg_nodes = 7'd64;
   logic [2:0]  cfg_hubs  = 3'd1;
   logic [15:0] rate_col  = 16'd256;
   logic [15:0] rate_xfer = 16'd256;
   logic [15:0] rate_dst  = 16'd256;

   lane_item_type outbox [$];
   lane_item_type on_wire;
   route_rsp_type reply_due [$];
   route_rsp_type due;
   route_rsp_type want;
   int          issued_cnt = 0;
   int          accepted_cnt = 0;
   int          checked_cnt = 0;
   int          sent_items = 0;
   int          fail_cnt = 0;
   bit          calm = 1'b0;

   two_hub_route_min_cost_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int live_nodes();
      return (cfg_nodes > NODES) ? NODES : int'(cfg_nodes);
   endfunction

   function automatic int live_hubs();
      return (cfg_hubs > SLOTS) ? SLOTS : int'(cfg_hubs);
   endfunction

   // least-cost hub pair for a query, table update for a write
   function automatic route_rsp_type route_reply(input route_req_type q);
      route_rsp_type rep;
      int          n;
      int          r;
      int          si;
      int          sj;
      logic [5:0]  a;
      logic [5:0]  b;
      logic [63:0] traffic;
      logic [63:0] sum;
      logic [63:0] cost;
      logic [63:0] best;
      logic [5:0]  best_a;
      logic [5:0]  best_b;
      bit          have;
      n = live_nodes();
      r = live_hubs();
      rep = '0;
      rep.status = STAT_REJECT;
      if (q.row >= n) return rep;
      if (q.cmd == CMD_WR_HUB) begin
         if (q.slot >= r || q.value >= n) return rep;
         hub_mem[q.row*SLOTS + q.slot] = q.value[5:0];
         hub_ok[q.row*SLOTS + q.slot] = 1'b1;
         rep.status = STAT_WRITE_OK;
         return rep;
      end
      if (q.col >= n) return rep;
      if (q.cmd == CMD_WR_DIST) begin
         dist_mem[q.row*NODES + q.col] = q.value;
         dist_ok[q.row*NODES + q.col] = 1'b1;
         rep.status = STAT_WRITE_OK;
         return rep;
      end
      if (q.cmd == CMD_WR_TRAFFIC) begin
         traf_mem[q.row*NODES + q.col] = q.value;
         traf_ok[q.row*NODES + q.col] = 1'b1;
         rep.status = STAT_WRITE_OK;
         return rep;
      end
      if (r == 0) return rep;
      traffic = traf_mem[q.row*NODES + q.col];
      have = 1'b0;
      best = '0;
      best_a = '0;
      best_b = '0;
      for (si = 0; si < r; si++) begin
         a = hub_mem[q.row*SLOTS + si];
         for (sj = 0; sj < r; sj++) begin
            b = hub_mem[q.col*SLOTS + sj];
            sum = rate_col * dist_mem[q.row*NODES + a]
                + rate_xfer * dist_mem[a*NODES + b]
                + rate_dst * dist_mem[b*NODES + q.col];
            cost = traffic * sum;
            if (!have || cost < best) begin
               have = 1'b1;
               best = cost;
               best_a = a;
               best_b = b;
            end
         end
      end
      rep.status = STAT_ROUTE;
      rep.cost = best[49:0];
      rep.hub_a = best_a;
      rep.hub_b = best_b;
      return rep;
   endfunction

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            due = route_reply(on_wire.rq);
            if (on_wire.typed) due = on_wire.ans;
            reply_due = {reply_due, due};
            accepted_cnt++;
         end
         if (!req_tvalid || req_tready) begin
            if (outbox.size() > 0 && (calm || $urandom_range(0, 99) >= 18)) begin
               on_wire = outbox.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= on_wire.rq;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_due.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               fail_cnt++;
            end else begin
               want = reply_due.pop_front();
               checked_cnt++;
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
                  fail_cnt++;
               end
               if (rsp_tdata[51:2] !== want.cost) begin
                  $error("route_cost: expected %0d, got %0d", want.cost, rsp_tdata[51:2]);
                  fail_cnt++;
               end
               if (rsp_tdata[57:52] !== want.hub_a) begin
                  $error("first_hub: expected %0d, got %0d", want.hub_a, rsp_tdata[57:52]);
                  fail_cnt++;
               end
               if (rsp_tdata[63:58] !== want.hub_b) begin
                  $error("second_hub: expected %0d, got %0d", want.hub_b, rsp_tdata[63:58]);
                  fail_cnt++;
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 18);
      end
   end

   task automatic send(input lane_item_type it);
      outbox = {outbox, it};
      issued_cnt++;
      sent_items++;
      wait (accepted_cnt == issued_cnt);
   endtask

   task automatic put(input cmd_type c, input int row, input int col, input int slot,
                      input int value);
      lane_item_type it;
      it.rq.cmd = c;
      it.rq.row = row[5:0];
      it.rq.col = col[5:0];
      it.rq.slot = slot[1:0];
      it.rq.value = value[15:0];
      it.typed = 1'b0;
      it.ans = '0;
      send(it);
   endtask

   task automatic drain();
      wait (accepted_cnt == issued_cnt && checked_cnt == accepted_cnt);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_NODE_COUNT:    cfg_nodes = val[6:0];
         CSR_HUBS_PER_NODE: cfg_hubs  = val[2:0];
         CSR_COLLECT_RATE:  rate_col  = val;
         CSR_TRANSFER_RATE: rate_xfer = val;
         CSR_DISTRIB_RATE:  rate_dst  = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int pick_value();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 16'hFFFF;
         2, 3: return $urandom_range(0, 65535);
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   function automatic int pick_node(input int n);
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, (n < 4) ? n - 1 : 3);
      return $urandom_range(0, n - 1);
   endfunction

   function automatic int pick_rate();
      case ($urandom_range(0, 9))
         0, 1: return 0;
         2, 3: return 16'hFFFF;
         4: return 256;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // load whatever a query on (i, j) would read that is not loaded yet
   task automatic prepare_route(input int i, input int j);
      int n;
      int r;
      int s;
      int t;
      int a;
      int b;
      n = live_nodes();
      r = live_hubs();
      for (s = 0; s < r; s++) begin
         if (!hub_ok[i*SLOTS + s] || hub_mem[i*SLOTS + s] >= n)
            put(CMD_WR_HUB, i, $urandom_range(0, 63), s, $urandom_range(0, n - 1));
         if (!hub_ok[j*SLOTS + s] || hub_mem[j*SLOTS + s] >= n)
            put(CMD_WR_HUB, j, $urandom_range(0, 63), s, $urandom_range(0, n - 1));
      end
      if (!traf_ok[i*NODES + j])
         put(CMD_WR_TRAFFIC, i, j, $urandom_range(0, 3), pick_value());
      for (s = 0; s < r; s++) begin
         for (t = 0; t < r; t++) begin
            a = hub_mem[i*SLOTS + s];
            b = hub_mem[j*SLOTS + t];
            if (!dist_ok[i*NODES + a])
               put(CMD_WR_DIST, i, a, $urandom_range(0, 3), pick_value());
            if (!dist_ok[a*NODES + b])
               put(CMD_WR_DIST, a, b, $urandom_range(0, 3), pick_value());
            if (!dist_ok[b*NODES + j])
               put(CMD_WR_DIST, b, j, $urandom_range(0, 3), pick_value());
         end
      end
   endtask

   function automatic plan_step_type csr_row(input logic [2:0] idx, input logic [15:0] val);
      plan_step_type p;
      p = '{default: '0};
      p.is_csr = 1'b1;
      p.idx = idx;
      p.wdata = val;
      return p;
   endfunction

   function automatic plan_step_type req_row(input cmd_type c, input int row, input int col,
                                             input int slot, input int value,
                                             input bit typed = 1'b0,
                                             input status_type st = STAT_REJECT,
                                             input logic [49:0] cost = '0,
                                             input int ha = 0, input int hb = 0);
      plan_step_type p;
      p = '{default: '0};
      p.item.rq.cmd = c;
      p.item.rq.row = row[5:0];
      p.item.rq.col = col[5:0];
      p.item.rq.slot = slot[1:0];
      p.item.rq.value = value[15:0];
      p.item.typed = typed;
      p.item.ans.status = st;
      p.item.ans.cost = cost;
      p.item.ans.hub_a = ha[5:0];
      p.item.ans.hub_b = hb[5:0];
      return p;
   endfunction

   initial begin
      plan_step_type plan [$];
      lane_item_type it;
      int         phase;
      int         budget;
      int         pick;
      int         n;
      int         r;
      int         i;
      int         j;
      int         nodes;
      int         hubs;
      logic [15:0] raw;

      plan = {plan, req_row(CMD_WR_DIST,    63, 63, 3, 16'hFFFF, 1, STAT_WRITE_OK)};
      plan = {plan, req_row(CMD_WR_TRAFFIC, 63, 63, 0, 16'hFFFF, 1, STAT_WRITE_OK)};
      plan = {plan, req_row(CMD_WR_HUB,     63,  0, 0, 63,       1, STAT_WRITE_OK)};
      plan = {plan, req_row(CMD_QUERY,      63, 63, 0, 0,        1, STAT_ROUTE,
                            50'd3298434220800, 63, 63)};
      // slot beyond hubs per node, then hub index beyond node count
      plan = {plan, req_row(CMD_WR_HUB,      0,  0, 1, 0,        1, STAT_REJECT)};
      plan = {plan, req_row(CMD_WR_HUB,      0,  0, 0, 16'hFFFF, 1, STAT_REJECT)};
      plan = {plan, csr_row(CSR_NODE_COUNT, 16'd3)};
      plan = {plan, req_row(CMD_WR_DIST,     5,  0, 0, 7,        1, STAT_REJECT)};
      plan = {plan, req_row(CMD_WR_TRAFFIC,  0, 63, 0, 7,        1, STAT_REJECT)};
      plan = {plan, req_row(CMD_QUERY,       2, 40, 0, 0,        1, STAT_REJECT)};
      // hub writes ignore col_node
      plan = {plan, req_row(CMD_WR_HUB,      1, 63, 0, 2,        1, STAT_WRITE_OK)};
      plan = {plan, csr_row(CSR_HUBS_PER_NODE, 16'd0)};
      plan = {plan, req_row(CMD_QUERY,       0,  0, 0, 0,        1, STAT_REJECT)};
      plan = {plan, req_row(CMD_WR_HUB,      0,  0, 0, 0,        1, STAT_REJECT)};
      plan = {plan, csr_row(CSR_HUBS_PER_NODE, 16'd7)};
      plan = {plan, csr_row(CSR_NODE_COUNT, 16'd0)};
      plan = {plan, req_row(CMD_WR_DIST,     0,  0, 0, 1,        1, STAT_REJECT)};
      plan = {plan, req_row(CMD_QUERY,       0,  0, 0, 0,        1, STAT_REJECT)};
      plan = {plan, csr_row(CSR_NODE_COUNT, 16'd100)};
      plan = {plan, csr_row(3'd5, 16'hFFFF)};
      plan = {plan, csr_row(3'd6, 16'h0000)};
      plan = {plan, csr_row(3'd7, 16'hFFFF)};
      plan = {plan, req_row(CMD_WR_HUB,     63,  0, 3, 63,       1, STAT_WRITE_OK)};
      plan = {plan, req_row(CMD_WR_HUB,     63,  0, 1, 63,       1, STAT_WRITE_OK)};
      plan = {plan, req_row(CMD_WR_HUB,     63,  0, 2, 63,       1, STAT_WRITE_OK)};
      plan = {plan, req_row(CMD_WR_DIST,     0, 63, 0, 0,        1, STAT_WRITE_OK)};
      plan = {plan, csr_row(CSR_COLLECT_RATE, 16'hFFFF)};
      plan = {plan, csr_row(CSR_TRANSFER_RATE, 16'hFFFF)};
      plan = {plan, csr_row(CSR_DISTRIB_RATE, 16'hFFFF)};
      plan = {plan, req_row(CMD_QUERY,      63, 63, 0, 0,        1, STAT_ROUTE,
                            50'd844386276016125, 63, 63)};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         if (plan[k].is_csr) begin
            drain();
            write_reg(plan[k].idx, plan[k].wdata);
         end else begin
            send(plan[k].item);
         end
      end

      phase = 0;
      while (sent_items < 750) begin
         drain();
         calm = (phase == 1);
         case (phase)
            0: nodes = 1;
            1: nodes = 5;
            2: nodes = 127;
            3: nodes = 64;
            default:
               case ($urandom_range(0, 9))
                  0: nodes = 1;
                  1: nodes = 64;
                  2: nodes = $urandom_range(65, 127);
                  3: nodes = 0;
                  default: nodes = $urandom_range(2, 6);
               endcase
         endcase
         case (phase)
            0, 1: hubs = 4;
            2: hubs = 2;
            3: hubs = 1;
            default:
               case ($urandom_range(0, 19))
                  0: hubs = 0;
                  1, 2: hubs = $urandom_range(5, 7);
                  default: hubs = $urandom_range(1, 4);
               endcase
         endcase
         raw = $urandom;
         raw[6:0] = nodes[6:0];
         write_reg(CSR_NODE_COUNT, raw);
         raw = $urandom;
         raw[2:0] = hubs[2:0];
         write_reg(CSR_HUBS_PER_NODE, raw);
         write_reg(CSR_COLLECT_RATE,  (phase == 0) ? 16'd0 : (phase == 1) ? 16'hFFFF
                                      : 16'(pick_rate()));
         write_reg(CSR_TRANSFER_RATE, (phase == 0) ? 16'd0 : (phase == 1) ? 16'hFFFF
                                      : 16'(pick_rate()));
         write_reg(CSR_DISTRIB_RATE,  (phase == 0) ? 16'd0 : (phase == 1) ? 16'hFFFF
                                      : 16'(pick_rate()));
         if ($urandom_range(0, 3) == 0)
            write_reg(3'($urandom_range(5, 7)), 16'($urandom));

         budget = sent_items + ((nodes == 0) ? 10 : $urandom_range(50, 90));
         while (sent_items < budget && sent_items < 750) begin
            n = live_nodes();
            r = live_hubs();
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
               drain();
            end else if (pick < 57 && n > 0 && r > 0) begin
               i = pick_node(n);
               j = pick_node(n);
               prepare_route(i, j);
               if ($urandom_range(0, 3) == 0)
                  put(CMD_WR_TRAFFIC, i, j, $urandom_range(0, 3), pick_value());
               if ($urandom_range(0, 3) == 0)
                  put(CMD_WR_DIST, i, hub_mem[i*SLOTS], $urandom_range(0, 3), pick_value());
               put(CMD_QUERY, i, j, $urandom_range(0, 3), $urandom_range(0, 65535));
            end else if (pick < 80 && n > 0) begin
               case ($urandom_range(0, 2))
                  0: put(CMD_WR_DIST, pick_node(n), pick_node(n), $urandom_range(0, 3),
                         pick_value());
                  1: put(CMD_WR_TRAFFIC, pick_node(n), pick_node(n), $urandom_range(0, 3),
                         pick_value());
                  default: put(CMD_WR_HUB, pick_node(n), $urandom_range(0, 63),
                               (r > 0) ? $urandom_range(0, r - 1) : $urandom_range(0, 3),
                               $urandom_range(0, n - 1));
               endcase
            end else begin
               // raw noise; a query that would read the tables gets its entries first
               it.rq = route_req_type'($urandom);
               it.typed = 1'b0;
               it.ans = '0;
               if (it.rq.cmd == CMD_QUERY && it.rq.row < n && it.rq.col < n && r > 0)
                  prepare_route(it.rq.row, it.rq.col);
               send(it);
            end
         end
         phase++;
      end

      drain();
      repeat (40) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/hrmc_pkg.sv
hdl/hrmc_tables.sv
hdl/hrmc_eval.sv
hdl/two_hub_route_min_cost_unit.sv
tb/two_hub_route_min_cost_unit_test.sv
